// ===== src/cfra_pkg.sv =====
// Shared constants, types and control-word layout of the continued-fraction approximator.
package cfra_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int RATIO_W    = 32;
    localparam int TOL_W      = 16;
    localparam int LIM_W      = 11;
    localparam int DENOM_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIM_W-1:0] LIM_MAX   = LIM_W'(1024);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TERM_LIMIT = CFG_IDX_W'(1);

    // Remainder pair num/den of the Euclid expansion and its quotient.
    localparam int NUM_W     = FRAC_BITS;
    localparam int DEN_W     = FRAC_BITS + 1;
    localparam int QUOT_W    = DEN_W;
    localparam int DIV_STEPS = QUOT_W;

    // Convergents: a*p1 + p0 with p1, p0 below the limit, or the integer part.
    localparam int P_W_LOOP  = QUOT_W + LIM_W;
    localparam int P_W_INT   = RATIO_W - FRAC_BITS + 1;
    localparam int P_W       = (P_W_LOOP > P_W_INT) ? P_W_LOOP : P_W_INT;

    // Shared multiplier: A side takes ratio, tolerance or quotient.
    localparam int MUL_A_W   = RATIO_W;
    localparam int MUL_B_W   = (DEN_W > LIM_W) ? DEN_W : LIM_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIFF_W    = RATIO_W + LIM_W;

    localparam int UPC_W     = 4;

    typedef enum logic [1:0] {
        MA_TOL,
        MA_RATIO,
        MA_QUOT
    } t_mula;

    typedef enum logic [1:0] {
        MB_DEN,
        MB_Q1,
        MB_P1
    } t_mulb;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_LIM_FAIL,
        COND_REM_SMALL,
        COND_ERR_OK,
        COND_NUM_ZERO,
        COND_DIV_BUSY
    } t_cond;

    typedef struct packed {
        t_mula             mula;
        t_mulb             mulb;
        logic              mul_en;
        t_cond             cond;
        logic [UPC_W-1:0]  target;
        logic              diff_en;
        logic              div_go;
        logic              upd_p;
        logic              upd_q;
        logic              done;
    } t_uword;

    typedef struct packed {
        logic lim_fail;
        logic rem_small;
        logic err_ok;
        logic num_zero;
        logic div_busy;
    } t_flags;

    localparam t_uword UW_NOP = '{
        mula:    MA_TOL,
        mulb:    MB_DEN,
        mul_en:  1'b0,
        cond:    COND_NONE,
        target:  '0,
        diff_en: 1'b0,
        div_go:  1'b0,
        upd_p:   1'b0,
        upd_q:   1'b0,
        done:    1'b0
    };

endpackage

// ===== src/cfra_if.sv =====
// Handshake channel interfaces: ratio input, fraction result and register writes.
interface cfra_in_if;
    import cfra_pkg::*;

    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] ratio_q;

    modport source (output valid, output ratio_q, input ready);
    modport sink   (input valid, input ratio_q, output ready);
endinterface

interface cfra_out_if;
    import cfra_pkg::*;

    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] numer_q;
    logic [DENOM_W-1:0] denom;
    logic               approximated;

    modport source (output valid, output numer_q, output denom, output approximated,
                     input ready);
    modport sink   (input valid, input numer_q, input denom, input approximated,
                     output ready);
endinterface

interface cfra_cfg_if;
    import cfra_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/cfra_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Euclid step den / num.
module cfra_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [cfra_pkg::DEN_W-1:0]   i_dividend,
    input  logic [cfra_pkg::NUM_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic [cfra_pkg::QUOT_W-1:0]  o_quot,
    output logic [cfra_pkg::NUM_W-1:0]   o_rem
);
    import cfra_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_rem;
    logic [QUOT_W-1:0]  r_quo;
    logic [NUM_W-1:0]   r_dvs;

    logic [NUM_W:0]     shifted;
    logic [NUM_W+1:0]   trial;
    logic               fits;
    logic [NUM_W-1:0]   n_rem;

    // The partial remainder stays below the divisor, so one subtract per bit suffices.
    always_comb begin
        shifted = {r_rem, r_quo[QUOT_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        fits    = !trial[NUM_W+1];
        n_rem   = fits ? trial[NUM_W-1:0] : shifted[NUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUOT_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== src/cfra_dp.sv =====
// Datapath: convergent and remainder registers, shared multiplier, divider and stop tests.
module cfra_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfra_pkg::RATIO_W-1:0]  i_ratio,
    input  logic [cfra_pkg::TOL_W-1:0]    i_tol,
    input  logic [cfra_pkg::LIM_W-1:0]    i_lim,
    input  cfra_pkg::t_uword              i_uw,
    output cfra_pkg::t_flags              o_flags,
    output logic [cfra_pkg::RATIO_W-1:0]  o_numer_q,
    output logic [cfra_pkg::DENOM_W-1:0]  o_denom,
    output logic                          o_approximated
);
    import cfra_pkg::*;

    localparam int EXT_W = P_W + RATIO_W;

    logic [RATIO_W-1:0] r_ratio;
    logic [P_W-1:0]     r_p0;
    logic [P_W-1:0]     r_p1;
    logic [P_W-1:0]     r_q0;
    logic [P_W-1:0]     r_q1;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [PROD_W-1:0]  r_prod;
    logic [DIFF_W-1:0]  r_diff;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [DIFF_W-1:0]  p_scaled;
    logic [DIFF_W-1:0]  qr;
    logic [P_W-1:0]     lim_ext;
    logic [EXT_W-1:0]   numer_ext;
    logic               numer_sat;

    logic               div_busy;
    logic [QUOT_W-1:0]  quot;
    logic [NUM_W-1:0]   rem;

    cfra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_uw.div_go),
        .i_dividend (r_den),
        .i_divisor  (r_num),
        .o_busy     (div_busy),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // Operand selection for the one multiplier. Inside the loop p1 and q1 stay
    // below the limit, so their low bits carry the whole value.
    always_comb begin
        unique case (i_uw.mula)
            MA_TOL:   mul_a = MUL_A_W'(i_tol);
            MA_RATIO: mul_a = r_ratio;
            MA_QUOT:  mul_a = MUL_A_W'(quot);
            default:  mul_a = '0;
        endcase
        unique case (i_uw.mulb)
            MB_DEN:  mul_b = MUL_B_W'(r_den);
            MB_Q1:   mul_b = MUL_B_W'(r_q1);
            MB_P1:   mul_b = MUL_B_W'(r_p1);
            default: mul_b = '0;
        endcase
    end

    always_comb begin
        p_scaled = DIFF_W'({r_p1, {FRAC_BITS{1'b0}}});
        qr       = r_prod[DIFF_W-1:0];
        lim_ext  = P_W'(i_lim);

        o_flags.lim_fail  = !((r_p1 < lim_ext) && (r_q1 < lim_ext));
        o_flags.rem_small = PROD_W'({r_num, {FRAC_BITS{1'b0}}}) < r_prod;
        o_flags.err_ok    = PROD_W'(r_diff) <= r_prod;
        o_flags.num_zero  = (r_num == '0);
        o_flags.div_busy  = div_busy;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ratio <= i_ratio;
            r_p0    <= P_W'(1);
            r_q0    <= '0;
            r_p1    <= P_W'(i_ratio >> FRAC_BITS);
            r_q1    <= P_W'(1);
            r_num   <= i_ratio[NUM_W-1:0];
            r_den   <= DEN_W'(1) << FRAC_BITS;
        end else begin
            if (i_uw.upd_p) begin
                r_p0 <= r_p1;
                r_p1 <= r_prod[P_W-1:0] + r_p0;
            end
            if (i_uw.upd_q) begin
                r_q0  <= r_q1;
                r_q1  <= r_prod[P_W-1:0] + r_q0;
                r_den <= DEN_W'(r_num);
                r_num <= rem;
            end
        end
        if (i_uw.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_uw.diff_en) begin
            r_diff <= (p_scaled > qr) ? (p_scaled - qr) : (qr - p_scaled);
        end
    end

    // Result: the convergent when accepted, the ratio itself over one otherwise.
    always_comb begin
        numer_ext = EXT_W'(r_p1) << FRAC_BITS;
        numer_sat = |numer_ext[EXT_W-1:RATIO_W];
        if (!o_flags.lim_fail) begin
            o_numer_q      = numer_sat ? '1 : numer_ext[RATIO_W-1:0];
            o_denom        = r_q1[DENOM_W-1:0];
            o_approximated = 1'b1;
        end else begin
            o_numer_q      = r_ratio;
            o_denom        = DENOM_W'(1);
            o_approximated = 1'b0;
        end
    end

endmodule

// ===== src/cfra_useq.sv =====
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
module cfra_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    input  cfra_pkg::t_flags  i_flags,
    output cfra_pkg::t_uword  o_uw,
    output logic              o_busy,
    output logic              o_finish
);
    import cfra_pkg::*;

    localparam logic [UPC_W-1:0] UPC_CHK_LIM  = UPC_W'(0);
    localparam logic [UPC_W-1:0] UPC_MUL_TD   = UPC_W'(1);
    localparam logic [UPC_W-1:0] UPC_CHK_REM  = UPC_W'(2);
    localparam logic [UPC_W-1:0] UPC_MUL_RQ   = UPC_W'(3);
    localparam logic [UPC_W-1:0] UPC_DIFF     = UPC_W'(4);
    localparam logic [UPC_W-1:0] UPC_MUL_TQ   = UPC_W'(5);
    localparam logic [UPC_W-1:0] UPC_CHK_ERR  = UPC_W'(6);
    localparam logic [UPC_W-1:0] UPC_CHK_ZERO = UPC_W'(7);
    localparam logic [UPC_W-1:0] UPC_DIV_GO   = UPC_W'(8);
    localparam logic [UPC_W-1:0] UPC_DIV_WAIT = UPC_W'(9);
    localparam logic [UPC_W-1:0] UPC_MUL_AP   = UPC_W'(10);
    localparam logic [UPC_W-1:0] UPC_UPD_P    = UPC_W'(11);
    localparam logic [UPC_W-1:0] UPC_MUL_AQ   = UPC_W'(12);
    localparam logic [UPC_W-1:0] UPC_UPD_Q    = UPC_W'(13);
    localparam logic [UPC_W-1:0] UPC_DONE     = UPC_W'(14);

    function automatic t_uword rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = UW_NOP;
        unique case (addr)
            UPC_CHK_LIM: begin
                w.cond   = COND_LIM_FAIL;
                w.target = UPC_DONE;
            end
            UPC_MUL_TD: begin
                w.mula   = MA_TOL;
                w.mulb   = MB_DEN;
                w.mul_en = 1'b1;
            end
            UPC_CHK_REM: begin
                w.cond   = COND_REM_SMALL;
                w.target = UPC_DONE;
            end
            UPC_MUL_RQ: begin
                w.mula   = MA_RATIO;
                w.mulb   = MB_Q1;
                w.mul_en = 1'b1;
            end
            UPC_DIFF: begin
                w.diff_en = 1'b1;
            end
            UPC_MUL_TQ: begin
                w.mula   = MA_TOL;
                w.mulb   = MB_Q1;
                w.mul_en = 1'b1;
            end
            UPC_CHK_ERR: begin
                w.cond   = COND_ERR_OK;
                w.target = UPC_DONE;
            end
            UPC_CHK_ZERO: begin
                w.cond   = COND_NUM_ZERO;
                w.target = UPC_DONE;
            end
            UPC_DIV_GO: begin
                w.div_go = 1'b1;
            end
            UPC_DIV_WAIT: begin
                w.cond   = COND_DIV_BUSY;
                w.target = UPC_DIV_WAIT;
            end
            UPC_MUL_AP: begin
                w.mula   = MA_QUOT;
                w.mulb   = MB_P1;
                w.mul_en = 1'b1;
            end
            UPC_UPD_P: begin
                w.upd_p = 1'b1;
            end
            UPC_MUL_AQ: begin
                w.mula   = MA_QUOT;
                w.mulb   = MB_Q1;
                w.mul_en = 1'b1;
            end
            UPC_UPD_Q: begin
                w.upd_q  = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = UPC_CHK_LIM;
            end
            UPC_DONE: begin
                w.done = 1'b1;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = UPC_DONE;
            end
        endcase
        return w;
    endfunction

    logic             r_busy;
    logic [UPC_W-1:0] r_upc;
    t_uword           uw;
    logic             jump;

    always_comb begin
        uw = r_busy ? rom(r_upc) : UW_NOP;
        unique case (uw.cond)
            COND_NONE:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_LIM_FAIL:  jump = i_flags.lim_fail;
            COND_REM_SMALL: jump = i_flags.rem_small;
            COND_ERR_OK:    jump = i_flags.err_ok;
            COND_NUM_ZERO:  jump = i_flags.num_zero;
            COND_DIV_BUSY:  jump = i_flags.div_busy;
            default:        jump = 1'b0;
        endcase
    end

    assign o_finish = r_busy && uw.done && i_out_free;
    assign o_busy   = r_busy;
    assign o_uw     = uw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= UPC_CHK_LIM;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_upc  <= UPC_CHK_LIM;
        end else if (r_busy) begin
            if (uw.done) begin
                // Hold on the final step until the result register can take the beat.
                if (i_out_free) begin
                    r_busy <= 1'b0;
                end
            end else if (jump) begin
                r_upc <= uw.target;
            end else begin
                r_upc <= r_upc + UPC_W'(1);
            end
        end
    end

endmodule

// ===== src/continued_fraction_ratio_approx_top.sv =====
// Top level of the continued-fraction ratio approximator.
//
//  channel   dir  modport  payload
//  i_in      in   sink     ratio_q (Q16.16)
//  o_out     out  source   numer_q (Q16.16), denom, approximated
//  i_cfg     in   sink     index (0 tolerance, 1 term_limit), data
//
// An item holds the sequencer for its whole Euclid expansion; each round runs the
// restoring divider and makes five passes through the one multiplier.
// Reset is synchronous and active low; it loads tolerance 7 and term_limit 1000.
// One item is in work at a time; a new beat is taken while a result still waits.
// A stalled output holds the sequencer on its final step; i_cfg is always ready.
module continued_fraction_ratio_approx_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfra_in_if.sink     i_in,
    cfra_out_if.source  o_out,
    cfra_cfg_if.sink    i_cfg
);
    import cfra_pkg::*;

    logic [TOL_W-1:0]   r_tol;
    logic [LIM_W-1:0]   r_lim;
    logic [LIM_W-1:0]   lim_eff;

    logic               r_out_valid;
    logic [RATIO_W-1:0] r_numer_q;
    logic [DENOM_W-1:0] r_denom;
    logic               r_approximated;

    logic               busy;
    logic               start;
    logic               finish;
    logic               out_free;
    t_uword             uw;
    t_flags             flags;
    logic [RATIO_W-1:0] res_numer_q;
    logic [DENOM_W-1:0] res_denom;
    logic               res_approximated;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_lim <= LIM_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TOLERANCE:  r_tol <= i_cfg.data[TOL_W-1:0];
                REG_TERM_LIMIT: r_lim <= i_cfg.data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Saturate the limit so an accepted denominator fits the result field.
    assign lim_eff = (r_lim > LIM_MAX) ? LIM_MAX : r_lim;

    assign i_in.ready = !busy;
    assign start      = i_in.valid && !busy;
    assign out_free   = !r_out_valid || o_out.ready;

    cfra_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_uw       (uw),
        .o_busy     (busy),
        .o_finish   (finish)
    );

    cfra_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_ratio        (i_in.ratio_q),
        .i_tol          (r_tol),
        .i_lim          (lim_eff),
        .i_uw           (uw),
        .o_flags        (flags),
        .o_numer_q      (res_numer_q),
        .o_denom        (res_denom),
        .o_approximated (res_approximated)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_numer_q      <= res_numer_q;
            r_denom        <= res_denom;
            r_approximated <= res_approximated;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.numer_q      = r_numer_q;
    assign o_out.denom        = r_denom;
    assign o_out.approximated = r_approximated;

endmodule

// ===== bench/tb_continued_fraction_ratio_approx_top.sv =====
// Self-checking testbench of the continued-fraction ratio approximator top level.
`timescale 1ns / 100ps

module tb_continued_fraction_ratio_approx_top;
    import cfra_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 125;
    localparam int MAX_IDLE         = 16;

    typedef struct packed {
        logic [RATIO_W-1:0] numer_q;
        logic [DENOM_W-1:0] denom;
        logic               approximated;
    } t_fraction;

    logic i_clk;
    logic i_rst_n;

    cfra_in_if  in_ch ();
    cfra_out_if out_ch ();
    cfra_cfg_if cfg_ch ();

    continued_fraction_ratio_approx_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Register copies used by the predictor.
    logic [TOL_W-1:0] tol_reg = TOL_RESET;
    logic [LIM_W-1:0] lim_reg = LIM_RESET;

    t_fraction pending_fractions [$];

    int  err_count    = 0;
    int  n_sent       = 0;
    int  n_checked    = 0;
    int  n_approx     = 0;
    int  n_fallback   = 0;
    int  n_reg_writes = 0;
    bit  in_idle_on   = 1'b1;
    bit  out_idle_on  = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Timeout with %0d results outstanding", pending_fractions.size());
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Euclid expansion of ratio / 2^FRAC_BITS with the current registers.
    function automatic t_fraction predict_fraction(input logic [RATIO_W-1:0] ratio);
        logic [63:0] one_q, r, tol, lim;
        logic [63:0] p_prev, q_prev, p_cur, q_cur, p_next, q_next;
        logic [63:0] rem_num, rem_den, rem_next, quot;
        logic [63:0] p_scaled, q_scaled, err, numer;
        t_fraction   res;
        one_q   = 64'd1 << FRAC_BITS;
        r       = 64'(ratio);
        tol     = 64'(tol_reg);
        lim     = 64'(lim_reg);
        if (lim > 64'(LIM_MAX))
            lim = 64'(LIM_MAX);
        p_prev  = 64'd1;
        q_prev  = 64'd0;
        p_cur   = r >> FRAC_BITS;
        q_cur   = 64'd1;
        rem_num = r & (one_q - 64'd1);
        rem_den = one_q;
        while (p_cur < lim && q_cur < lim) begin
            if (rem_num * one_q < tol * rem_den)
                break;
            p_scaled = p_cur * one_q;
            q_scaled = q_cur * r;
            err = (p_scaled > q_scaled) ? p_scaled - q_scaled : q_scaled - p_scaled;
            if (err <= tol * q_cur)
                break;
            if (rem_num == 64'd0)
                break;
            quot     = rem_den / rem_num;
            p_next   = quot * p_cur + p_prev;
            q_next   = quot * q_cur + q_prev;
            p_prev   = p_cur;
            q_prev   = q_cur;
            p_cur    = p_next;
            q_cur    = q_next;
            rem_next = rem_den % rem_num;
            rem_den  = rem_num;
            rem_num  = rem_next;
        end
        if (p_cur < lim && q_cur < lim) begin
            numer = p_cur << FRAC_BITS;
            if (numer > 64'hFFFF_FFFF)
                numer = 64'hFFFF_FFFF;
            res.numer_q      = numer[RATIO_W-1:0];
            res.denom        = q_cur[DENOM_W-1:0];
            res.approximated = 1'b1;
        end else begin
            res.numer_q      = ratio;
            res.denom        = DENOM_W'(1);
            res.approximated = 1'b0;
        end
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_ratio(input logic [RATIO_W-1:0] ratio);
        int gap;
        gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.ratio_q <= ratio;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_fractions.push_back(predict_fraction(ratio));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Holds the input off until every outstanding result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_fractions.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_TOLERANCE)
            tol_reg = data[TOL_W-1:0];
        else if (idx == REG_TERM_LIMIT)
            lim_reg = data[LIM_W-1:0];
        n_reg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [RATIO_W-1:0] gen_ratio();
        logic [63:0] p, q, r;
        int          ip, lim_eff;
        case ($urandom_range(0, 5))
            0: r = 64'($urandom());
            1: r = {32'd0, 16'($urandom_range(0, 3)), 16'($urandom())};
            2: begin
                p = 64'($urandom_range(0, 300));
                q = 64'($urandom_range(1, 300));
                r = ((p << FRAC_BITS) / q) + 64'($urandom_range(0, 2));
            end
            3: begin
                lim_eff = (int'(lim_reg) > int'(LIM_MAX)) ? int'(LIM_MAX) : int'(lim_reg);
                ip = lim_eff + $urandom_range(0, 4) - 2;
                if (ip < 0)
                    ip = 0;
                r = {32'd0, 16'(ip), 16'($urandom())};
            end
            4: r = 64'($urandom_range(0, 64));
            default: begin
                if ($urandom_range(0, 1) == 0)
                    r = {32'd0, 16'($urandom_range(0, 40)), 16'hFFFF - 16'($urandom_range(0, 8))};
                else
                    r = {32'd0, 16'($urandom_range(1, 40)), 16'($urandom_range(0, 8))};
            end
        endcase
        return r[RATIO_W-1:0];
    endfunction

    // Result sink with a random stall drawn before each beat.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            stall = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_fractions.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h/%0d flag %b",
                    out_ch.numer_q, out_ch.denom, out_ch.approximated));
            end else begin
                want = pending_fractions.pop_front();
                n_checked++;
                if (want.approximated)
                    n_approx++;
                else
                    n_fallback++;
                if (out_ch.numer_q !== want.numer_q)
                    report_mismatch($sformatf("numer_q %h, predicted %h",
                        out_ch.numer_q, want.numer_q));
                if (out_ch.denom !== want.denom)
                    report_mismatch($sformatf("denom %0d, predicted %0d",
                        out_ch.denom, want.denom));
                if (out_ch.approximated !== want.approximated)
                    report_mismatch($sformatf("approximated %b, predicted %b",
                        out_ch.approximated, want.approximated));
            end
        end
    end

    task automatic test_reset_defaults();
        logic [RATIO_W-1:0] ratios [12] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000,
            32'h0003_243F, 32'h0001_9E37, 32'h0000_0001, 32'h0000_FFFF,
            32'h03E7_0000, 32'h03E8_0000, 32'h0001_AAAB, 32'h0000_5555
        };
        foreach (ratios[i])
            send_ratio(ratios[i]);
        drain_results();
    endtask

    task automatic test_tolerance_extremes();
        logic [RATIO_W-1:0] exact_ratios [4] = '{
            32'h0003_243F, 32'h0001_9E37, 32'h0000_0001, 32'h0000_8001
        };
        write_reg(REG_TOLERANCE, 16'h0000);
        foreach (exact_ratios[i])
            send_ratio(exact_ratios[i]);
        drain_results();
        // The widest tolerance should stop every expansion at the integer part.
        write_reg(REG_TOLERANCE, 16'hFFFF);
        send_ratio(32'h0003_243F);
        send_ratio(32'h00FF_8000);
        drain_results();
        write_reg(REG_TOLERANCE, TOL_RESET);
    endtask

    task automatic test_limit_extremes();
        write_reg(REG_TERM_LIMIT, 16'd0);
        send_ratio(32'h0000_8000);
        send_ratio(32'h0000_0000);
        drain_results();
        write_reg(REG_TERM_LIMIT, 16'd1);
        send_ratio(32'h0001_0000);
        drain_results();
        write_reg(REG_TERM_LIMIT, 16'd2);
        send_ratio(32'h0001_8000);
        drain_results();
        write_reg(REG_TERM_LIMIT, 16'd1024);
        send_ratio(32'h03FF_C000);
        drain_results();
        // Upper data bits are dropped and the limit saturates at 1024.
        write_reg(REG_TERM_LIMIT, 16'hFFFF);
        send_ratio(32'h0003_243F);
        drain_results();
        write_reg(REG_TERM_LIMIT, 16'hFC10);
        send_ratio(32'h0400_0000);
        drain_results();
        // Writes to unused indexes must leave both registers alone.
        write_reg(REG_SPARE_2, 16'h0001);
        write_reg(REG_SPARE_3, 16'hFFFF);
        send_ratio(32'h0001_9E37);
        drain_results();
        write_reg(REG_TERM_LIMIT, 16'(LIM_RESET));
    endtask

    task automatic test_random_ratios();
        logic [CFG_DATA_W-1:0] tol_val, lim_val;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: tol_val = 16'h0000;
                1: tol_val = 16'hFFFF;
                2: tol_val = 16'($urandom_range(0, 15));
                default: tol_val = 16'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0: lim_val = 16'($urandom_range(0, 2));
                1: lim_val = 16'($urandom_range(1000, 1100));
                2: lim_val = 16'($urandom());
                default: lim_val = 16'($urandom_range(2, 2047));
            endcase
            if (ph == 0) begin
                tol_val = TOL_RESET;
                lim_val = 16'(LIM_RESET);
            end
            write_reg(REG_TOLERANCE, tol_val);
            write_reg(REG_TERM_LIMIT, lim_val);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 40 == 0) begin
                    in_idle_on  = ($urandom_range(0, 3) != 0);
                    out_idle_on = ($urandom_range(0, 3) != 0);
                end
                send_ratio(gen_ratio());
                if ($urandom_range(0, 63) == 0)
                    drain_results();
            end
            drain_results();
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.ratio_q <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_TOLERANCE;
        cfg_ch.data   <= '0;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_tolerance_extremes();
        test_limit_extremes();
        test_random_ratios();

        drain_results();
        repeat (64) @(negedge i_clk);
        if (pending_fractions.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_fractions.size()));

        $display("Checked %0d of %0d ratios over %0d register writes.",
            n_checked, n_sent, n_reg_writes);
        $display("Results: %0d convergents accepted, %0d fallbacks, %0d mismatches.",
            n_approx, n_fallback, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
